@@ hdl/bc_pkg.sv @@
// Shared types and constants for the binomial coefficient core.
`default_nettype none
package bc_pkg;

   localparam int FIELD_WIDTH      = 8;
   localparam int COEFF_WIDTH      = 64;
   localparam int RESULT_WIDTH_DEF = 64;
   // multiplier bits per step (n + 1 - i is at most 127)
   localparam int MULT_WIDTH       = 7;
   // divisor bits per step (i is at most 63)
   localparam int DIV_WIDTH        = 6;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] n_value;
      logic signed [FIELD_WIDTH-1:0] r_value;
   } req_type;

   typedef struct packed {
      logic [COEFF_WIDTH-1:0] coefficient;
      logic                   saturated;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/bc_mul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none
module bc_mul #(
   parameter int VALUE_WIDTH = bc_pkg::RESULT_WIDTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [VALUE_WIDTH-1:0]                   value,
   input  wire logic [bc_pkg::MULT_WIDTH-1:0]            factor,
   output logic                                          done,
   output logic [VALUE_WIDTH+bc_pkg::MULT_WIDTH-1:0]     product
);
   import bc_pkg::*;

   localparam int PW = VALUE_WIDTH + MULT_WIDTH;
   localparam int CW = $clog2(MULT_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [MULT_WIDTH-1:0]  factor_ff, factor_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PW-1:0]          acc_ff, acc_in;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      factor_in = factor_ff;
      value_in  = value_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CW'(MULT_WIDTH - 1);
         factor_in = factor;
         value_in  = value;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = (acc_ff << 1) + (factor_ff[MULT_WIDTH-1] ? PW'(value_ff) : '0);
         factor_in = factor_ff << 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      factor_ff <= factor_in;
      value_ff  <= value_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

@@ hdl/bc_div.sv @@
// Radix-2 restoring divider: one quotient bit per cycle, narrow remainder.
`default_nettype none
module bc_div #(
   parameter int DIVIDEND_WIDTH = bc_pkg::RESULT_WIDTH_DEF + bc_pkg::MULT_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DIVIDEND_WIDTH-1:0]     dividend,
   input  wire logic [bc_pkg::DIV_WIDTH-1:0]  divisor,
   output logic                               done,
   output logic [DIVIDEND_WIDTH-1:0]          quotient
);
   import bc_pkg::*;

   localparam int CW = $clog2(DIVIDEND_WIDTH);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [DIV_WIDTH-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] work_ff, work_in;
   logic [DIV_WIDTH:0]        trial;
   logic [DIV_WIDTH:0]        diff;
   logic                      fits;

   always_comb begin
      trial = {rem_ff, work_ff[DIVIDEND_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = !diff[DIV_WIDTH];
   end

   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      done_in    = 1'b0;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CW'(DIVIDEND_WIDTH - 1);
         divisor_in = divisor;
         rem_in     = '0;
         work_in    = dividend;
      end else if (busy_ff) begin
         // shift the dividend out at the top, quotient bits in at the bottom
         rem_in  = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         work_in = {work_ff[DIVIDEND_WIDTH-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      work_ff    <= work_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule
`default_nettype wire

@@ hdl/binomial_coefficient_core.sv @@
// A request runs k = min(r, n - r) steps, cut short once the value saturates; a step is a bit-serial
// multiply followed by a restoring divide. Worst case at RESULT_WIDTH = 64: 33 steps (n = 67,
// r = 33); invalid or trivial inputs run no step. One item at a time; the next request is taken
// while the last result still waits on rsp_stall. Reset (synchronous, active high) clears the
// sequencer and result valid.
// Top level of the binomial coefficient core.
`default_nettype none
module binomial_coefficient_core #(
   parameter int RESULT_WIDTH = bc_pkg::RESULT_WIDTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire bc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output bc_pkg::rsp_type      rsp_data
);
   import bc_pkg::*;

   localparam int PW = RESULT_WIDTH + MULT_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [COEFF_WIDTH-1:0] SAT_VALUE = COEFF_WIDTH'({RESULT_WIDTH{1'b1}});

   logic [2:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [RESULT_WIDTH-1:0] v_ff, v_in;
   logic [MULT_WIDTH-1:0]   m_ff, m_in;
   logic [DIV_WIDTH-1:0]    i_ff, i_in;
   logic [DIV_WIDTH-1:0]    rr_ff, rr_in;
   logic                    sat_ff, sat_in;

   logic                    mul_start, mul_done;
   logic [PW-1:0]           product;
   logic                    div_start, div_done;
   logic [PW-1:0]           quotient;

   logic                    accept;
   logic                    bad_input;
   logic [FIELD_WIDTH-1:0]  n_minus_r;
   logic [FIELD_WIDTH-1:0]  r_bits;
   logic [DIV_WIDTH-1:0]    r_short;

   bc_mul #(
      .VALUE_WIDTH (RESULT_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .value   (v_ff),
      .factor  (m_ff),
      .done    (mul_done),
      .product (product)
   );

   bc_div #(
      .DIVIDEND_WIDTH (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (i_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign mul_start = (state_ff == ST_LAUNCH);
   assign div_start = (state_ff == ST_MUL) && mul_done;

   always_comb begin
      r_bits    = req_data.r_value;
      n_minus_r = req_data.n_value - req_data.r_value;
      bad_input = req_data.n_value[FIELD_WIDTH-1] || req_data.r_value[FIELD_WIDTH-1]
                  || (req_data.n_value < req_data.r_value);
      // mirror r to the smaller side
      r_short   = (r_bits > n_minus_r) ? n_minus_r[DIV_WIDTH-1:0] : r_bits[DIV_WIDTH-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      rr_in        = rr_ff;
      sat_in       = sat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               m_in   = req_data.n_value[MULT_WIDTH-1:0];
               i_in   = DIV_WIDTH'(1);
               rr_in  = r_short;
               sat_in = 1'b0;
               if (bad_input) begin
                  v_in     = '0;
                  state_in = ST_FINISH;
               end else begin
                  v_in     = RESULT_WIDTH'(1);
                  state_in = (r_short == '0) ? ST_FINISH : ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (|quotient[PW-1:RESULT_WIDTH]) begin
                  // running value only grows from here: stop and saturate
                  sat_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  v_in = quotient[RESULT_WIDTH-1:0];
                  if (i_ff == rr_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     m_in     = m_ff - 1'b1;
                     state_in = ST_LAUNCH;
                  end
               end
            end
         end
         ST_FINISH: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.coefficient = sat_ff ? SAT_VALUE : COEFF_WIDTH'(v_ff);
               rsp_in.saturated   = sat_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      m_ff   <= m_in;
      i_ff   <= i_in;
      rr_ff  <= rr_in;
      sat_ff <= sat_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request transfer did not start the sequencer");

   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.coefficient == SAT_VALUE)
      else $error("saturated result is not the limit value");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> i_ff != '0 && i_ff <= rr_ff)
      else $error("step index outside 1 .. k");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");
`endif

endmodule
`default_nettype wire

@@ sim/binomial_coefficient_checker.sv @@
// Checker for the binomial coefficient core: predicts C(n, r) per request and compares results.
`timescale 1ns / 1ps
module binomial_coefficient_checker #(
   parameter int RESULT_WIDTH = bc_pkg::RESULT_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  bc_pkg::req_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  bc_pkg::rsp_type rsp_data,
   output int              mismatch_count,
   output int              outstanding
);

   bc_pkg::rsp_type coefficient_queue[$];

   // Multiplicative method: v = v * (n + 1 - i) / i, exact at every step.
   function automatic bc_pkg::rsp_type binomial_of(bc_pkg::req_type item);
      int              n;
      int              r;
      int              k;
      logic [63:0]     ceiling;
      logic [63:0]     running;
      logic [127:0]    wide;
      bc_pkg::rsp_type answer;
      n = $signed(item.n_value);
      r = $signed(item.r_value);
      ceiling = {64{1'b1}} >> (64 - RESULT_WIDTH);
      answer.coefficient = '0;
      answer.saturated = 1'b0;
      if (n < 0 || r < 0 || n < r)
         return answer;
      k = (r > n - r) ? n - r : r;
      running = 64'd1;
      for (int i = 1; i <= k; i++) begin
         wide = ({64'd0, running} * 128'(n + 1 - i)) / 128'(i);
         // the coefficient only grows up to k, so once past the ceiling stop there
         if (wide > {64'd0, ceiling}) begin
            answer.coefficient = ceiling;
            answer.saturated = 1'b1;
            return answer;
         end
         running = wide[63:0];
      end
      answer.coefficient = running;
      return answer;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      bc_pkg::rsp_type want;
      if (!reset) begin
         // pop first: a result never belongs to the request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (coefficient_queue.size() == 0) begin
               $display("%0t: unexpected result: expected none, got coefficient %0d saturated %0b",
                        $time, rsp_data.coefficient, rsp_data.saturated);
               mismatch_count++;
            end else begin
               want = coefficient_queue.pop_front();
               if (rsp_data.coefficient !== want.coefficient) begin
                  $display("%0t: coefficient mismatch: expected %0d, got %0d",
                           $time, want.coefficient, rsp_data.coefficient);
                  mismatch_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated mismatch: expected %0b, got %0b",
                           $time, want.saturated, rsp_data.saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            coefficient_queue.push_back(binomial_of(req_data));
      end
      outstanding <= coefficient_queue.size();
   end

endmodule

@@ sim/binomial_coefficient_core_tb.sv @@
// Testbench top for the binomial coefficient core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module binomial_coefficient_core_tb;

   localparam int RESULT_WIDTH = bc_pkg::RESULT_WIDTH_DEF;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 106;
   localparam int SETTLE_CYCLES = 64;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   bc_pkg::req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   bc_pkg::rsp_type rsp_data;
   int              mismatch_count;
   int              outstanding;
   int              cycle_count = 0;
   logic            quiet = 1'b0;

   binomial_coefficient_core #(.RESULT_WIDTH(RESULT_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   binomial_coefficient_checker #(.RESULT_WIDTH(RESULT_WIDTH)) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request after a random gap; return on the edge of its transfer.
   task automatic send_request(input logic [7:0] n, input logic [7:0] r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{n_value: n, r_value: r};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Result side: hold off each result for a random number of cycles.
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 11);
         rsp_stall <= (hold != 0);
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (hold != 0) begin
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   initial begin
      int pick;
      int n;
      int r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: empty sets, full range, invalid signs, trivial and overflow boundaries
      send_request(8'd0, 8'd0);
      send_request(8'd1, 8'd1);
      send_request(8'd1, 8'd0);
      send_request(8'd127, 8'd0);
      send_request(8'd127, 8'd127);
      send_request(8'd127, 8'd1);
      send_request(8'd127, 8'd126);
      send_request(8'd127, 8'd63);
      send_request(8'd127, 8'd64);
      send_request(-8'sd128, 8'd0);
      send_request(8'd0, -8'sd128);
      send_request(-8'sd1, -8'sd1);
      send_request(-8'sd128, 8'd127);
      send_request(8'd127, -8'sd128);
      send_request(8'd100, -8'sd5);
      send_request(-8'sd5, 8'd3);
      send_request(8'd5, 8'd7);
      send_request(8'd10, 8'd5);
      send_request(8'd62, 8'd31);
      send_request(8'd66, 8'd33);
      send_request(8'd67, 8'd33);
      send_request(8'd67, 8'd34);
      send_request(8'd68, 8'd34);
      send_request(8'd68, 8'd33);

      drain_results();

      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         quiet = (item >= 50 && item < 80);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            n = $urandom_range(0, 127);
            r = $urandom_range(0, n);
         end else if (pick == 7) begin
            n = $urandom_range(0, 126);
            r = $urandom_range(n + 1, 127);
         end else begin
            n = $urandom;
            r = $urandom;
         end
         send_request(n[7:0], r[7:0]);
         if (item == 95)
            drain_results();
      end
      quiet = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/bc_pkg.sv
hdl/bc_mul.sv
hdl/bc_div.sv
hdl/binomial_coefficient_core.sv
sim/binomial_coefficient_checker.sv
sim/binomial_coefficient_core_tb.sv
